// File: src/fab_pkg.sv
package fab_pkg;

	// Field widths of the pixel stream
	localparam int COL_W = 12;
	localparam int OV_W = 13;
	localparam int CH_W = 8;

	// Blend weight precision and the overlap limit
	localparam int ALPHA_FRAC_BITS = 16;
	localparam int MAX_COLUMNS = 4096;

	// Packed stream widths, rounded up to whole bytes
	localparam int IN_BITS = COL_W + 6 * CH_W;
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 3 * CH_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [CH_W-1:0] ch_t;
	typedef logic [ALPHA_FRAC_BITS-1:0] alpha_t;

	typedef struct packed {
		ch_t red;
		ch_t green;
		ch_t blue;
	} pix_t;

	// Load enables of the multiply stage and the output stage
	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} mix_ctl_t;

endpackage

// File: src/fab_channel_mix.sv
module fab_channel_mix (
	input  logic             clk,
	input  fab_pkg::mix_ctl_t ctl,
	input  fab_pkg::alpha_t  alpha,
	input  fab_pkg::ch_t     nv,
	input  fab_pkg::ch_t     bv,
	input  logic             blend,
	output fab_pkg::ch_t     out_ch
);

	localparam int FRAC = fab_pkg::ALPHA_FRAC_BITS;
	localparam int CH_W = fab_pkg::CH_W;
	localparam int PN_W = FRAC + CH_W;
	localparam int PB_W = FRAC + 1 + CH_W;
	localparam logic [FRAC:0] ONE_Q = (FRAC+1)'(1) << FRAC;
	localparam logic [PN_W:0] HALF_N = (PN_W+1)'(1) << (FRAC - 1);
	localparam logic [PB_W:0] HALF_B = (PB_W+1)'(1) << (FRAC - 1);
	localparam logic [CH_W+1:0] CH_MAX = (CH_W+2)'((1 << CH_W) - 1);

	logic [FRAC:0] inv_alpha;
	logic [PN_W-1:0] prod_n_s3;
	logic [PB_W-1:0] prod_b_s3;
	fab_pkg::ch_t nv_s3;
	logic blend_s3;
	logic [PN_W:0] rnd_n;
	logic [PB_W:0] rnd_b;
	logic [CH_W+1:0] mix_sum;
	fab_pkg::ch_t mix_sat;

	assign inv_alpha = ONE_Q - {1'b0, alpha};

	// Form both weighted products
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			prod_n_s3 <= PN_W'(alpha) * PN_W'(nv);
			prod_b_s3 <= PB_W'(inv_alpha) * PB_W'(bv);
			nv_s3 <= nv;
			blend_s3 <= blend;
		end
	end

	// Round each product half up, add and clamp
	always_comb begin
		rnd_n = {1'b0, prod_n_s3} + HALF_N;
		rnd_b = {1'b0, prod_b_s3} + HALF_B;
		mix_sum = (CH_W+2)'(rnd_n[PN_W:FRAC]) + rnd_b[PB_W:FRAC];
		mix_sat = (mix_sum > CH_MAX) ? CH_MAX[CH_W-1:0] : mix_sum[CH_W-1:0];
	end

	// Hold blended or copied channel
	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			out_ch <= blend_s3 ? mix_sat : nv_s3;
		end
	end

endmodule

// File: src/feather_alpha_pixel_blend.sv
// Linear feather blend of BGR pixels, one accepted per clock unless stalled.
// A pixel whose column lies below overlap_width is mixed with the base image
// pixel by alpha = floor(column * 2^16 / overlap), each channel the sum of two
// half-up rounded products clamped to 255; other pixels pass through with
// m_tuser low. overlap_width above 4096 acts as 4096, zero copies everything.
// The pipeline has one capture stage, a chain of 16 restoring divider stages
// (one quotient bit each), a multiply stage and a round/clamp output stage.
// Every stage advances on its own, so bubbles close up under back-pressure.
// Write overlap_width only while the pipeline is empty.
module feather_alpha_pixel_blend (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [fab_pkg::OV_W-1:0]  cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// column[11:0], new_blue[19:12], new_green[27:20], new_red[35:28],
	// base_blue[43:36], base_green[51:44], base_red[59:52], zero fill
	input  logic [fab_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// out_blue[7:0], out_green[15:8], out_red[23:16]
	output logic [fab_pkg::OUT_W-1:0] m_tdata,
	// in_overlap[0]
	output logic                      m_tuser
);

	localparam int FRAC = fab_pkg::ALPHA_FRAC_BITS;
	localparam int OV_W = fab_pkg::OV_W;
	localparam int COL_W = fab_pkg::COL_W;
	localparam int CH_W = fab_pkg::CH_W;
	localparam logic [OV_W-1:0] OV_MAX = OV_W'(fab_pkg::MAX_COLUMNS);

	logic [OV_W-1:0] ov_q;
	logic [OV_W-1:0] ov_sat;
	logic [COL_W-1:0] in_col;
	fab_pkg::pix_t in_new;
	fab_pkg::pix_t in_base;

	logic v_s1;
	logic rdy_s1;
	logic [OV_W-1:0] ov_s1;
	logic [OV_W-1:0] rem_s1;
	logic blend_s1;
	fab_pkg::pix_t new_s1;
	fab_pkg::pix_t base_s1;

	logic [FRAC-1:0] v_s2;
	logic [FRAC-1:0] rdy_s2;
	logic [OV_W-1:0] ov_s2 [FRAC];
	logic [OV_W-1:0] rem_s2 [FRAC];
	fab_pkg::alpha_t q_s2 [FRAC];
	logic [FRAC-1:0] blend_s2;
	fab_pkg::pix_t new_s2 [FRAC];
	fab_pkg::pix_t base_s2 [FRAC];

	logic v_s3;
	logic v_s4;
	logic rdy_s3;
	logic rdy_s4;
	logic blend_s3;
	logic blend_s4;
	fab_pkg::mix_ctl_t mix_ctl;
	fab_pkg::alpha_t alpha;
	fab_pkg::pix_t new_last;
	fab_pkg::pix_t base_last;
	fab_pkg::pix_t out_pix;

	// Hold overlap width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= '0;
		end else if (cfg_we) begin
			ov_q <= cfg_wdata;
		end
	end

	// Unpack request and clamp overlap
	always_comb begin
		in_col = s_tdata[COL_W-1:0];
		in_new.blue = s_tdata[COL_W +: CH_W];
		in_new.green = s_tdata[COL_W+CH_W +: CH_W];
		in_new.red = s_tdata[COL_W+2*CH_W +: CH_W];
		in_base.blue = s_tdata[COL_W+3*CH_W +: CH_W];
		in_base.green = s_tdata[COL_W+4*CH_W +: CH_W];
		in_base.red = s_tdata[COL_W+5*CH_W +: CH_W];
		ov_sat = (ov_q > OV_MAX) ? OV_MAX : ov_q;
	end

	// Per-stage ready: advance when the next stage is empty or moving
	always_comb begin
		rdy_s4 = !v_s4 || m_tready;
		rdy_s3 = !v_s3 || rdy_s4;
		rdy_s2[FRAC-1] = !v_s2[FRAC-1] || rdy_s3;
		for (int k = FRAC - 2; k >= 0; k--) begin
			rdy_s2[k] = !v_s2[k] || rdy_s2[k+1];
		end
		rdy_s1 = !v_s1 || rdy_s2[0];
	end

	assign s_tready = rdy_s1;

	// Capture request and test the overlap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			ov_s1 <= ov_sat;
			rem_s1 <= OV_W'(in_col);
			blend_s1 <= (OV_W'(in_col) < ov_sat);
			new_s1 <= in_new;
			base_s1 <= in_base;
		end
	end

	// Restoring divider: one quotient bit per stage
	for (genvar k = 0; k < FRAC; k++) begin : g_div
		logic v_in;
		logic [OV_W-1:0] ov_in;
		logic [OV_W-1:0] rem_in;
		fab_pkg::alpha_t q_in;
		logic blend_in;
		fab_pkg::pix_t new_in;
		fab_pkg::pix_t base_in;
		logic [OV_W:0] rem_dbl;
		logic [OV_W:0] rem_sub;
		logic take;

		if (k == 0) begin : g_head
			assign v_in = v_s1;
			assign ov_in = ov_s1;
			assign rem_in = rem_s1;
			assign q_in = '0;
			assign blend_in = blend_s1;
			assign new_in = new_s1;
			assign base_in = base_s1;
		end else begin : g_body
			assign v_in = v_s2[k-1];
			assign ov_in = ov_s2[k-1];
			assign rem_in = rem_s2[k-1];
			assign q_in = q_s2[k-1];
			assign blend_in = blend_s2[k-1];
			assign new_in = new_s2[k-1];
			assign base_in = base_s2[k-1];
		end

		always_comb begin
			rem_dbl = {rem_in, 1'b0};
			rem_sub = rem_dbl - {1'b0, ov_in};
			take = (rem_dbl >= {1'b0, ov_in});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2[k] <= 1'b0;
			end else if (rdy_s2[k]) begin
				v_s2[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_s2[k]) begin
				ov_s2[k] <= ov_in;
				rem_s2[k] <= take ? rem_sub[OV_W-1:0] : rem_dbl[OV_W-1:0];
				q_s2[k] <= {q_in[FRAC-2:0], take};
				blend_s2[k] <= blend_in;
				new_s2[k] <= new_in;
				base_s2[k] <= base_in;
			end
		end
	end

	assign alpha = q_s2[FRAC-1];
	assign new_last = new_s2[FRAC-1];
	assign base_last = base_s2[FRAC-1];
	assign mix_ctl.en_s3 = rdy_s3;
	assign mix_ctl.en_s4 = rdy_s4;

	// Advance the multiply and output stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) begin
				v_s3 <= v_s2[FRAC-1];
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			blend_s3 <= blend_s2[FRAC-1];
		end
		if (rdy_s4) begin
			blend_s4 <= blend_s3;
		end
	end

	fab_channel_mix u_mix_blue (
		.clk    (clk),
		.ctl    (mix_ctl),
		.alpha  (alpha),
		.nv     (new_last.blue),
		.bv     (base_last.blue),
		.blend  (blend_s2[FRAC-1]),
		.out_ch (out_pix.blue)
	);

	fab_channel_mix u_mix_green (
		.clk    (clk),
		.ctl    (mix_ctl),
		.alpha  (alpha),
		.nv     (new_last.green),
		.bv     (base_last.green),
		.blend  (blend_s2[FRAC-1]),
		.out_ch (out_pix.green)
	);

	fab_channel_mix u_mix_red (
		.clk    (clk),
		.ctl    (mix_ctl),
		.alpha  (alpha),
		.nv     (new_last.red),
		.bv     (base_last.red),
		.blend  (blend_s2[FRAC-1]),
		.out_ch (out_pix.red)
	);

	// Pack result
	assign m_tvalid = v_s4;
	assign m_tuser = blend_s4;
	assign m_tdata = fab_pkg::OUT_W'({out_pix.red, out_pix.green, out_pix.blue});

endmodule
